// File: design/u16u8_pkg.sv
`default_nettype none
package u16u8_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] BOM_UNIT  = 16'hFEFF;
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // one encoded code point, up to four bytes
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  // everything one input item causes, up to six bytes
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      len;
  } seq_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp <= 21'h7FF) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

  function automatic seq_t merge_seq(input enc_t a, input enc_t b);
    seq_t       s;
    logic [2:0] j;
    s = '0;
    for (int i = 0; i < 6; i++) begin
      j = 3'(i) - a.len;
      if (3'(i) < a.len) begin
        s.bytes[i] = a.b[2'(i)];
      end else if (j < 3'd4) begin
        s.bytes[i] = b.b[j[1:0]];
      end else begin
        s.bytes[i] = '0;
      end
    end
    s.len = a.len + b.len;
    return s;
  endfunction

endpackage
`default_nettype wire

// File: design/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder.
// Input queue side: in_byte/in_end_of_stream, one raw UTF-16 byte per
// transfer, taken when push is high and full is low. Bytes pair into code
// units in the order set by cfg_data (1: low byte first), written with
// cfg_we while idle, a rule for the user that the block does not enforce.
// A 0xFEFF unit is dropped; a high surrogate waits for its partner.
// Output queue side: out_byte/out_last_of_run show the oldest UTF-8 byte
// while empty is low; pop takes it. out_last_of_run marks the final byte
// caused by one input byte (zero to six bytes per input).
// With the back side idle, the first byte of a result is written into the
// queue and then loaded into the back side's work register, where it shows.
// Throughput: one output byte per cycle while pop is high and results wait,
// set by the serialiser on the back side; input runs at one byte per cycle
// while the queue between front and back has room, so the sustained input
// rate is one byte per cycle or one per output byte, whichever is slower.
// Stalling pop holds the current byte; once the queue fills, full rises.
// Reset (rst_n low, synchronous) empties the queue, clears the pending
// byte and held surrogate and sets little-endian order.
`default_nettype none
module utf16_to_utf8_transcoder_unit #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_stream,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            empty,
  input  wire logic       pop
);

  logic            little_endian_r;
  logic            accept;
  u16u8_pkg::seq_t seq, q_data;
  logic            seq_push, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b1;
    end else if (cfg_we) begin
      little_endian_r <= cfg_data;
    end
  end

  assign accept = push && !full;

  u16u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .little_endian    (little_endian_r),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .seq              (seq),
    .seq_push         (seq_push)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (seq_push),
    .wr_data (seq),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .empty           (empty),
    .pop             (pop)
  );

endmodule
`default_nettype wire

// File: design/u16u8_front.sv
`default_nettype none
module u16u8_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             little_endian,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end_of_stream,
  output u16u8_pkg::seq_t       seq,
  output logic                  seq_push
);

  logic [7:0]  first_byte_r, first_byte_nxt;
  logic        first_valid_r, first_valid_nxt;
  logic [15:0] held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;

  logic [15:0]       unit;
  logic              is_low, is_high, is_bom;
  u16u8_pkg::enc_t   slot_a, slot_b;

  assign unit = little_endian ? {in_byte, first_byte_r} : {first_byte_r, in_byte};

  always_comb begin
    is_low  = unit inside {[u16u8_pkg::LOW_FIRST:u16u8_pkg::LOW_LAST]};
    is_high = unit inside {[u16u8_pkg::HIGH_FIRST:u16u8_pkg::HIGH_LAST]};
    is_bom  = (unit == u16u8_pkg::BOM_UNIT);

    slot_a          = '0;
    slot_b          = '0;
    held_nxt        = held_r;
    held_valid_nxt  = held_valid_r;
    first_byte_nxt  = first_byte_r;
    first_valid_nxt = first_valid_r;

    if (first_valid_r) begin
      first_valid_nxt = 1'b0;
      if (held_valid_r) begin
        held_valid_nxt = 1'b0;
        if (is_low) begin
          slot_a = u16u8_pkg::encode_cp(u16u8_pkg::SUPP_BASE +
                                        {1'b0, held_r[9:0], unit[9:0]});
        end else begin
          slot_a = u16u8_pkg::encode_cp({5'd0, held_r});
        end
      end
      if (!(held_valid_r && is_low)) begin
        if (is_high) begin
          held_nxt       = unit;
          held_valid_nxt = 1'b1;
        end else if (!is_bom) begin
          slot_b = u16u8_pkg::encode_cp({5'd0, unit});
        end
      end
    end else if (!in_end_of_stream) begin
      first_byte_nxt  = in_byte;
      first_valid_nxt = 1'b1;
    end

    if (in_end_of_stream) begin
      if (held_valid_nxt) begin
        if (slot_a.len == 3'd0) begin
          slot_a = u16u8_pkg::encode_cp({5'd0, held_nxt});
        end else begin
          slot_b = u16u8_pkg::encode_cp({5'd0, held_nxt});
        end
      end
      held_valid_nxt  = 1'b0;
      first_valid_nxt = 1'b0;
    end
  end

  assign seq      = u16u8_pkg::merge_seq(slot_a, slot_b);
  assign seq_push = accept && (seq.len != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_valid_r <= 1'b0;
      held_valid_r  <= 1'b0;
    end else if (accept) begin
      first_valid_r <= first_valid_nxt;
      held_valid_r  <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_byte_r <= first_byte_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/u16u8_fifo.sv
`default_nettype none
module u16u8_fifo #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire u16u8_pkg::seq_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output u16u8_pkg::seq_t      rd_data,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_pkg::seq_t store [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/u16u8_back.sv
`default_nettype none
module u16u8_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u16u8_pkg::seq_t q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 empty,
  input  wire logic            pop
);

  u16u8_pkg::seq_t work_r;
  logic [2:0]      idx_r;
  logic            busy_r;
  logic            xfer, last;

  assign xfer            = pop && busy_r;
  assign last            = (idx_r == work_r.len - 3'd1);
  assign q_pop           = !q_empty && (!busy_r || (xfer && last));
  assign empty           = !busy_r;
  assign out_byte        = work_r.bytes[idx_r];
  assign out_last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_data;
    end
  end

endmodule
`default_nettype wire

// File: design/u16u8_checker.sv
`default_nettype none
module u16u8_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run,
  input wire logic       empty,
  input wire logic       pop
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled output changed");

  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_byte[7] && out_byte[6] |-> !out_last_of_run)
    else $error("lead byte closes a run");

  a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_byte[7] |-> out_last_of_run)
    else $error("single-byte sequence not last of run");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .empty           (empty),
  .pop             (pop)
);
`default_nettype wire

// File: sim/utf16_to_utf8_transcoder_unit_chk.sv
`timescale 1ns / 100ps
module utf16_to_utf8_transcoder_unit_chk (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_stream,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last_of_run,
  input  wire logic       empty,
  input  wire logic       pop,
  output int              mismatches,
  output int              outstanding,
  output int              bytes_in,
  output int              bytes_out,
  output int              pairs_seen,
  output int              lone_seen
);

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } utf8_byte_t;

  logic        le_order   = 1'b1;
  logic [7:0]  lead_byte  = '0;
  logic        lead_valid = 1'b0;
  logic [15:0] high_unit  = '0;
  logic        high_valid = 1'b0;

  utf8_byte_t utf8_due[$];
  utf8_byte_t step_bytes[$];
  utf8_byte_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    bytes_in    = 0;
    bytes_out   = 0;
    pairs_seen  = 0;
    lone_seen   = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("%0t: utf8 %s: got %02h, expected %02h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  function automatic void put_utf8(input logic [7:0] v);
    utf8_byte_t nb;
    nb.val     = v;
    nb.last    = 1'b0;
    step_bytes = {step_bytes, nb};
  endfunction

  function automatic void encode_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_utf8(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      put_utf8(8'hC0 | 8'((cp >> 6) & 21'h1F));
      put_utf8(8'h80 | 8'(cp & 21'h3F));
    end else if (cp <= 21'hFFFF) begin
      put_utf8(8'hE0 | 8'((cp >> 12) & 21'h0F));
      put_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      put_utf8(8'h80 | 8'(cp & 21'h3F));
    end else begin
      put_utf8(8'hF0 | 8'((cp >> 18) & 21'h07));
      put_utf8(8'h80 | 8'((cp >> 12) & 21'h3F));
      put_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      put_utf8(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  function automatic void take_unit(input logic [15:0] u);
    logic [20:0] cp;
    if (high_valid) begin
      high_valid = 1'b0;
      if (u >= u16u8_pkg::LOW_FIRST && u <= u16u8_pkg::LOW_LAST) begin
        cp = u16u8_pkg::SUPP_BASE +
             ((21'(high_unit - u16u8_pkg::HIGH_FIRST) << 10) |
              21'(u - u16u8_pkg::LOW_FIRST));
        high_unit = '0;
        encode_point(cp);
        pairs_seen++;
        return;
      end
      encode_point(21'(high_unit));
      high_unit = '0;
      lone_seen++;
    end
    if (u == u16u8_pkg::BOM_UNIT) return;
    if (u >= u16u8_pkg::HIGH_FIRST && u <= u16u8_pkg::HIGH_LAST) begin
      high_unit  = u;
      high_valid = 1'b1;
      return;
    end
    if (u >= u16u8_pkg::LOW_FIRST && u <= u16u8_pkg::LOW_LAST) lone_seen++;
    encode_point(21'(u));
  endfunction

  function automatic void transcode_byte(input logic [7:0] b, input logic eos);
    logic [15:0] u;
    step_bytes.delete();
    if (!lead_valid) begin
      if (!eos) begin
        lead_byte  = b;
        lead_valid = 1'b1;
      end
    end else begin
      u = le_order ? {b, lead_byte} : {lead_byte, b};
      lead_valid = 1'b0;
      lead_byte  = '0;
      take_unit(u);
    end
    if (eos) begin
      if (high_valid) begin
        encode_point(21'(high_unit));
        lone_seen++;
      end
      lead_byte  = '0;
      lead_valid = 1'b0;
      high_unit  = '0;
      high_valid = 1'b0;
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
    utf8_due = {utf8_due, step_bytes};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      le_order   = 1'b1;
      lead_byte  = '0;
      lead_valid = 1'b0;
      high_unit  = '0;
      high_valid = 1'b0;
      utf8_due.delete();
    end else begin
      // result side first, so a byte can never match a same-edge prediction
      if (pop && !empty) begin
        if (utf8_due.size() == 0) begin
          report_mismatch("byte with nothing due", out_byte, 8'h00);
        end else begin
          want = utf8_due.pop_front();
          if (out_byte !== want.val) report_mismatch("out_byte", out_byte, want.val);
          if (out_last_of_run !== want.last) begin
            report_mismatch("out_last_of_run", 8'(out_last_of_run), 8'(want.last));
          end
          bytes_out++;
        end
      end
      if (cfg_we) le_order = cfg_data;
      if (push && !full) begin
        transcode_byte(in_byte, in_end_of_stream);
        bytes_in++;
      end
    end
    outstanding <= utf8_due.size();
  end

endmodule

// File: sim/utf16_to_utf8_transcoder_unit_tb.sv
`timescale 1ns / 100ps
module utf16_to_utf8_transcoder_unit_tb;

  localparam int STALL_CYCLES = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_BYTES  = 90;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       cfg_we           = 1'b0;
  logic       cfg_data         = 1'b1;
  logic [7:0] in_byte          = '0;
  logic       in_end_of_stream = 1'b0;
  logic       push             = 1'b0;
  logic       pop              = 1'b0;
  logic       full;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       empty;

  logic stall_req = 1'b0;
  logic calm      = 1'b0;
  logic tb_le     = 1'b1;
  int   bytes_sent = 0;
  int   idle_cycles = 0;

  int mismatches, outstanding, bytes_in, bytes_out, pairs_seen, lone_seen;

  always #5 clk = ~clk;

  utf16_to_utf8_transcoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .push             (push),
    .full             (full),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .empty            (empty),
    .pop              (pop)
  );

  utf16_to_utf8_transcoder_unit_chk chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .push             (push),
    .full             (full),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .empty            (empty),
    .pop              (pop),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .bytes_in         (bytes_in),
    .bytes_out        (bytes_out),
    .pairs_seen       (pairs_seen),
    .lone_seen        (lone_seen)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side
  initial begin
    wait (rst_n);
    forever begin
      if (stall_req) begin
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 20);
        @(posedge clk);
      end
    end
  end

  task automatic xfer(input logic [7:0] b, input logic eos);
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push             <= 1'b1;
    in_byte          <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_unit(input logic [15:0] u, input logic eos);
    if (tb_le) begin
      xfer(u[7:0], 1'b0);
      xfer(u[15:8], eos);
    end else begin
      xfer(u[15:8], 1'b0);
      xfer(u[7:0], eos);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(input logic le);
    cfg_data <= le;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tb_le = le;
  endtask

  task automatic random_units();
    int          r;
    logic        eos;
    logic [15:0] hi, lo;
    r   = $urandom_range(99);
    eos = ($urandom_range(99) < 6);
    hi  = 16'($urandom_range(u16u8_pkg::HIGH_LAST, u16u8_pkg::HIGH_FIRST));
    lo  = 16'($urandom_range(u16u8_pkg::LOW_LAST, u16u8_pkg::LOW_FIRST));
    if (r < 4) begin
      // stray byte, knocks the unit alignment off until the next end of stream
      xfer(8'($urandom_range(255)), 1'b0);
    end else if (r < 7) begin
      xfer(8'($urandom_range(255)), 1'b1);
    end else if (r < 25) begin
      send_unit(16'($urandom_range(16'h7F)), eos);
    end else if (r < 40) begin
      send_unit(16'($urandom_range(16'h7FF, 16'h80)), eos);
    end else if (r < 58) begin
      send_unit(16'($urandom_range(16'hFFFF, 16'h800)), eos);
    end else if (r < 62) begin
      send_unit(u16u8_pkg::BOM_UNIT, eos);
    end else if (r < 84) begin
      send_unit(hi, 1'b0);
      send_unit(lo, eos);
    end else if (r < 91) begin
      send_unit(hi, eos);
    end else begin
      send_unit(lo, eos);
    end
  endtask

  initial begin
    int start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // little-endian after reset
    send_unit(16'h0000, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(u16u8_pkg::BOM_UNIT, 1'b0);
    send_unit(u16u8_pkg::HIGH_LAST, 1'b0);
    send_unit(u16u8_pkg::LOW_LAST, 1'b0);
    send_unit(u16u8_pkg::HIGH_FIRST, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(u16u8_pkg::LOW_FIRST, 1'b0);
    send_unit(u16u8_pkg::HIGH_FIRST, 1'b0);
    xfer(8'hFF, 1'b1);
    send_unit(16'h007F, 1'b1);
    xfer(8'h41, 1'b1);

    // order change between the two bytes of a unit
    drain();
    write_order(1'b1);
    xfer(8'h12, 1'b0);
    drain();
    write_order(1'b0);
    xfer(8'h34, 1'b0);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_order(p == 3 ? 1'($urandom_range(1)) : ~p[0]);
      if (p == 1) stall_req = 1'b1;
      calm = (p == 2);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_units();
    end
    calm = 1'b0;
    drain();

    $display("%0d UTF-16 bytes in, %0d UTF-8 bytes out, in both byte orders", bytes_in,
             bytes_out);
    $display("%0d surrogate pairs, %0d lone surrogates, one long output stall",
             pairs_seen, lone_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
